/* hdl/ame_pkg.sv */
// Shared constants, types and the character decoder of the expression evaluator.
`timescale 1ns / 1ps

package ame_pkg;

   localparam int unsigned CHAR_W          = 8;
   localparam int unsigned VALUE_W         = 14;
   localparam int unsigned REQ_DATA_W      = 8;
   localparam int unsigned RSP_DATA_W      = 16;
   localparam int unsigned DEFAULT_MODULUS = 10000;

   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

   typedef enum logic [2:0] {
      KIND_OTHER,
      KIND_DIGIT,
      KIND_STAR,
      KIND_PLUS,
      KIND_NEWLINE
   } char_kind_type;

   function automatic char_kind_type decode_char(input logic [CHAR_W-1:0] code);
      char_kind_type kind;
      unique case (code) inside
         [CH_ZERO:CH_NINE]: kind = KIND_DIGIT;
         CH_STAR:           kind = KIND_STAR;
         CH_PLUS:           kind = KIND_PLUS;
         CH_NEWLINE:        kind = KIND_NEWLINE;
         default:           kind = KIND_OTHER;
      endcase
      return kind;
   endfunction

endpackage

/* hdl/add_mul_expression_mod_evaluator_unit.sv */
// Top level: streaming evaluator of '+' and '*' expressions modulo a constant.
`timescale 1ns / 1ps

//  channel | direction | tdata bits (lowest first)      | one request carries
//  req_    | in        | [7:0] char_code                | one character
//  rsp_    | out       | [13:0] value, [15:14] zero     | one expression value
//
// One character is taken every cycle unless a newline waits; a result passes from its
// newline request through the input register and then the result register.
// The product of the open term is built digit by digit (ten times the term
// plus the product times the digit, then one reduction), so each character is
// a single registered update of the state registers.
// Reset clears the state at once; there is no clearing pass.
// Only a newline waits, and only while the result register holds an untaken result.
module add_mul_expression_mod_evaluator_unit #(
   parameter int unsigned MODULUS = ame_pkg::DEFAULT_MODULUS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ame_pkg::REQ_DATA_W-1:0]   req_tdata,   // [7:0] char_code
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ame_pkg::RSP_DATA_W-1:0]   rsp_tdata    // [13:0] value, [15:14] zero
);
   import ame_pkg::*;

   localparam int unsigned SW    = $clog2(MODULUS);
   localparam int unsigned TW    = SW + 5;
   localparam int unsigned EXT_W = (SW > VALUE_W) ? SW : VALUE_W;
   localparam int unsigned MAX_Q = 18;

   logic                stage_valid_ff, stage_valid_in;
   logic [CHAR_W-1:0]   stage_char_ff, stage_char_in;
   logic [SW-1:0]       term_ff, term_in;
   logic [SW-1:0]       prod_ff, prod_in;
   logic [SW-1:0]       sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;

   char_kind_type       kind;
   logic                rsp_free;
   logic                advance;
   logic [CHAR_W-1:0]   digit_wide;
   logic [3:0]          digit;
   logic [TW-1:0]       digit_total;
   logic [TW-1:0]       digit_sub;
   logic [SW-1:0]       term_digit;
   logic [SW:0]         close_sum;
   logic [SW-1:0]       close_red;
   logic [EXT_W-1:0]    close_ext;

   assign kind     = decode_char(stage_char_ff);
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign advance  = stage_valid_ff && ((kind != KIND_NEWLINE) || rsp_free);

   assign req_tready = !stage_valid_ff || advance;

   // The open term holds product * number, so a digit scales it by ten and adds
   // product * digit; the sum stays below nineteen times the modulus.
   always_comb begin
      digit_wide  = stage_char_ff - CH_ZERO;
      digit       = digit_wide[3:0];
      digit_total = (TW'(term_ff) << 3) + (TW'(term_ff) << 1)
                    + TW'(prod_ff) * TW'(digit);
      digit_sub   = '0;
      for (int k = 1; k <= MAX_Q; k++) begin
         if (digit_total >= TW'(k) * TW'(MODULUS)) begin
            digit_sub = TW'(k) * TW'(MODULUS);
         end
      end
      term_digit = SW'(digit_total - digit_sub);

      close_sum = (SW+1)'(sum_ff) + (SW+1)'(term_ff);
      if (close_sum >= (SW+1)'(MODULUS)) begin
         close_sum = close_sum - (SW+1)'(MODULUS);
      end
      close_red = close_sum[SW-1:0];
      close_ext = EXT_W'(close_red);
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_char_in  = stage_char_ff;
      if (req_tvalid && req_tready) begin
         stage_valid_in = 1'b1;
         stage_char_in  = req_tdata[CHAR_W-1:0];
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end

      term_in      = term_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      if (advance) begin
         unique case (kind)
            KIND_DIGIT: begin
               term_in = term_digit;
            end
            KIND_STAR: begin
               // The closed factor becomes the new product; the new number is empty.
               prod_in = term_ff;
               term_in = '0;
            end
            KIND_PLUS: begin
               sum_in  = close_red;
               prod_in = SW'(1);
               term_in = '0;
            end
            KIND_NEWLINE: begin
               rsp_value_in = close_ext[VALUE_W-1:0];
               rsp_valid_in = 1'b1;
               sum_in       = '0;
               prod_in      = SW'(1);
               term_in      = '0;
            end
            default: begin
               term_in = term_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         term_ff        <= '0;
         prod_ff        <= SW'(1);
         sum_ff         <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         term_ff        <= term_in;
         prod_ff        <= prod_in;
         sum_ff         <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_char_ff <= stage_char_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_value_ff);

   // Every state register stays reduced below the modulus.
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, term_ff} < (SW+1)'(MODULUS)) && ({1'b0, prod_ff} < (SW+1)'(MODULUS))
      && ({1'b0, sum_ff} < (SW+1)'(MODULUS)))
      else $error("state register not reduced below the modulus");

   // A newline that leaves the input register always lands in the result register.
   assert property (@(posedge clock) disable iff (reset)
      (advance && (kind == KIND_NEWLINE)) |=> rsp_valid_ff)
      else $error("newline request produced no result");

   // After a newline the evaluation state is back at its starting values.
   assert property (@(posedge clock) disable iff (reset)
      (advance && (kind == KIND_NEWLINE)) |=>
      (term_ff == '0) && (sum_ff == '0) && (prod_ff == SW'(1)))
      else $error("state not cleared after newline");

   // A '*' moves the finished factor into the product and empties the number.
   assert property (@(posedge clock) disable iff (reset)
      (advance && (kind == KIND_STAR)) |=> (prod_ff == $past(term_ff)) && (term_ff == '0))
      else $error("product not updated on multiply");

endmodule

/* test/tb.sv */
// Self-checking testbench for the streaming add/multiply expression evaluator.
`timescale 1ns / 1ps

module tb;
   import ame_pkg::*;

   localparam int unsigned MODULUS          = DEFAULT_MODULUS;
   localparam int unsigned RANDOM_CHARS     = 2000;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned IDLE_LIMIT       = 2000;
   localparam int unsigned DRAIN_CYCLES     = 10;
   localparam int unsigned REPORT_LIMIT     = 10;

   // Mirrors the evaluator state and keeps the values still owed by the block.
   class expr_scoreboard;
      int unsigned operand_value;
      int unsigned term_product;
      int unsigned closed_sum;
      logic [VALUE_W-1:0] expected_values[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         operand_value = 0;
         term_product  = 1 % MODULUS;
         closed_sum    = 0;
      endfunction

      // All state is held reduced, so a * b + c stays well inside 32 bits.
      function int unsigned mul_add(int unsigned a, int unsigned b, int unsigned c);
         return (a * b + c) % MODULUS;
      endfunction

      function void note_char(logic [CHAR_W-1:0] code);
         int unsigned total;
         if (code >= CH_ZERO && code <= CH_NINE) begin
            operand_value = mul_add(operand_value, 10, int'(code - CH_ZERO));
         end else if (code == CH_STAR) begin
            term_product  = mul_add(term_product, operand_value, 0);
            operand_value = 0;
         end else if (code == CH_PLUS) begin
            closed_sum    = mul_add(term_product, operand_value, closed_sum);
            term_product  = 1 % MODULUS;
            operand_value = 0;
         end else if (code == CH_NEWLINE) begin
            total = mul_add(term_product, operand_value, closed_sum);
            expected_values.push_back(total[VALUE_W-1:0]);
            clear();
         end
      endfunction

      function void check_value(logic [RSP_DATA_W-1:0] word);
         logic [VALUE_W-1:0] want;
         if (expected_values.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: result %0d with no expression waiting", word[VALUE_W-1:0]);
            return;
         end
         want = expected_values.pop_front();
         if (word !== {{(RSP_DATA_W-VALUE_W){1'b0}}, want}) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: value expected %0d, got %0d (tdata %h)",
                        want, word[VALUE_W-1:0], word);
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   expr_scoreboard scoreboard = new();
   int unsigned    sent_count = 0;
   bit             long_hold_pending = 1'b0;

   add_mul_expression_mod_evaluator_unit #(
      .MODULUS (MODULUS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short pauses, some none at all and now and then a long one.
   function automatic int unsigned gap_length();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 3) return 0;
      if (roll < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_char(input logic [CHAR_W-1:0] code, input bit eager);
      int unsigned gap;
      gap = 0;
      if (!eager && $urandom_range(0, 3) == 0) gap = gap_length();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      do @(posedge clock); while (!req_tready);
      scoreboard.note_char(code);
      sent_count++;
   endtask

   task automatic send_text(input string text);
      int i;
      for (i = 0; i < text.len(); i++) send_char(text[i], 1'b0);
   endtask

   // Well-formed lines with random operands, with the odd stray byte and broken line.
   task automatic send_expression();
      int unsigned operands;
      int unsigned digits;
      int unsigned roll;
      int unsigned i;
      int unsigned j;
      bit eager;
      eager = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)), eager);
      end else begin
         operands = $urandom_range(1, 6);
         for (i = 0; i < operands; i++) begin
            if (i != 0) send_char(($urandom_range(0, 1) != 0) ? CH_PLUS : CH_STAR, eager);
            roll = $urandom_range(0, 19);
            if (roll < 2) digits = 0;
            else if (roll < 17) digits = $urandom_range(1, 4);
            else digits = $urandom_range(5, 9);
            for (j = 0; j < digits; j++) begin
               if ($urandom_range(0, 39) == 0) send_char(8'($urandom_range(0, 255)), eager);
               send_char(CH_ZERO + 8'($urandom_range(0, 9)), eager);
            end
         end
      end
      send_char(CH_NEWLINE, eager);
   endtask

   // Result side: runs of readiness broken by stalls, one of them long when asked.
   initial begin : receiver
      int unsigned ready_run;
      int unsigned stall_run;
      forever begin
         ready_run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 8);
         repeat (ready_run) begin
            @(negedge clock);
            rsp_tready <= 1'b1;
         end
         if (long_hold_pending) begin
            stall_run = LONG_HOLD_CYCLES;
            long_hold_pending = 1'b0;
         end else begin
            stall_run = gap_length();
         end
         repeat (stall_run) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) scoreboard.check_value(rsp_tdata);
   end

   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int unsigned lines;
      lines = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Empty line, missing operands, ignored bytes, leading zeros and reduction.
      send_text("\n");
      send_text("3+\n");
      send_text("3*\n");
      send_text("*5\n");
      send_text("1 2");
      send_char(8'hFF, 1'b0);
      send_char(8'h00, 1'b0);
      send_text("\n");
      send_text("007*99999+9999\n");

      sent_count = 0;
      while (sent_count < RANDOM_CHARS) begin
         // Every so often the result side holds off so that a newline request backs up.
         if (lines % 100 == 0) long_hold_pending = 1'b1;
         send_expression();
         lines++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (scoreboard.expected_values.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (scoreboard.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/ame_pkg.sv
hdl/add_mul_expression_mod_evaluator_unit.sv
test/tb.sv
